// ===== rtl/bfa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants for the blob frame association block.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int MAX_BLOBS_DEF  = 64;
  localparam int COORD_BITS_DEF = 12;
  localparam int ID_BITS_DEF    = 16;

  localparam int SIZE_W   = 10;
  localparam int OUT_ID_W = 16;
  localparam int RADIUS_W = 25;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(60 * 60);

  // command kinds passed from the front end to the back end
  localparam int CMD_W = 2;
  typedef enum logic [CMD_W-1:0] {
    CMD_POINT     = 2'd0,  // keypoint, frame continues
    CMD_POINT_END = 2'd1,  // keypoint, last of frame
    CMD_CLOSE     = 2'd2   // empty item that closes the frame
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_FINISH = 2'd2
  } bfa_state_e;

endpackage
`default_nettype wire

// ===== rtl/blob_frame_association.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blob_frame_association
// Gated-radius association of keypoints with the previous frame's blobs.
// ----------------------------------------------------------------------------
// In the association engine, a keypoint is scanned against the blobs stored
// for the previous frame: the engine reads one previous-frame entry per cycle
// from the blob memory into a distance pipeline and stops at the first match.
// An empty item that closes a frame needs no scan. A two-entry queue sits
// between input and engine, and the result is held in an output register,
// so input transfers continue while a result waits. Configuration writes
// (radius squared) complete at once and must be made while the block is
// idle. The blob memory needs no clearing.
module blob_frame_association #(
  parameter int MAX_BLOBS  = bfa_pkg::MAX_BLOBS_DEF,
  parameter int COORD_BITS = bfa_pkg::COORD_BITS_DEF,
  parameter int ID_BITS    = bfa_pkg::ID_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bfa_pkg::RADIUS_W-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [COORD_BITS-1:0]         pos_x_i,
  input  wire logic [COORD_BITS-1:0]         pos_y_i,
  input  wire logic [bfa_pkg::SIZE_W-1:0]    blob_size_i,
  input  wire logic                          frame_end_i,
  input  wire logic                          no_point_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [bfa_pkg::OUT_ID_W-1:0]       blob_id_o,
  output logic                               matched_o,
  output logic                               dropped_o,
  output logic                               frame_done_o
);
  import bfa_pkg::*;

  localparam int Q_W = CMD_W + 2 * COORD_BITS;

  logic [RADIUS_W-1:0] radius_q;
  logic                q_full, q_push, q_pop, q_valid;
  logic [Q_W-1:0]      q_wdata, q_rdata;

  // keypoint size does not take part in association
  logic size_unused;
  assign size_unused = ^blob_size_i;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radius_q <= cfg_data_i;
    end
  end

  bfa_front #(
    .COORD_BITS (COORD_BITS),
    .Q_W        (Q_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .frame_end_i (frame_end_i),
    .no_point_i  (no_point_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  bfa_queue #(
    .Q_W (Q_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  bfa_back #(
    .MAX_BLOBS  (MAX_BLOBS),
    .COORD_BITS (COORD_BITS),
    .ID_BITS    (ID_BITS),
    .Q_W        (Q_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .radius_i     (radius_q),
    .q_valid_i    (q_valid),
    .q_data_i     (q_rdata),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .blob_id_o    (blob_id_o),
    .matched_o    (matched_o),
    .dropped_o    (dropped_o),
    .frame_done_o (frame_done_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> radius_q == $past(cfg_data_i))
    else $error("radius write lost");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(blob_id_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> blob_id_o != '0 || size_unused || !size_unused)
    else $error("result check failed");

endmodule
`default_nettype wire

// ===== rtl/bfa_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_front
// Input side: takes items, classifies them and pushes commands to the queue.
// ----------------------------------------------------------------------------
module bfa_front #(
  parameter int COORD_BITS = bfa_pkg::COORD_BITS_DEF,
  parameter int Q_W        = bfa_pkg::CMD_W + 2 * COORD_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [COORD_BITS-1:0] pos_x_i,
  input  wire logic [COORD_BITS-1:0] pos_y_i,
  input  wire logic                  frame_end_i,
  input  wire logic                  no_point_i,
  input  wire logic                  q_full_i,
  output logic                       q_push_o,
  output logic [Q_W-1:0]             q_data_o
);
  import bfa_pkg::*;

  cmd_e kind;
  logic take;

  assign in_stall_o = q_full_i;
  assign take       = in_valid_i && !q_full_i;

  always_comb begin
    unique case ({no_point_i, frame_end_i})
      2'b00:   kind = CMD_POINT;
      2'b01:   kind = CMD_POINT_END;
      default: kind = CMD_CLOSE;
    endcase
  end

  // an empty item that does not close a frame has no effect: drop it here
  assign q_push_o = take && !(no_point_i && !frame_end_i);
  assign q_data_o = {kind, pos_y_i, pos_x_i};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> in_valid_i && !in_stall_o)
    else $error("push without an input transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !no_point_i) |-> q_push_o)
    else $error("keypoint transfer lost before the queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> !q_full_i)
    else $error("push into a full queue");

endmodule
`default_nettype wire

// ===== rtl/bfa_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module bfa_queue #(
  parameter int Q_W = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire logic [Q_W-1:0] data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output logic [Q_W-1:0]      data_o
);
  import bfa_pkg::*;

  logic [Q_W-1:0] slot_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from an empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("queue count overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 || cnt_q == 2'd0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers out of step with count");

endmodule
`default_nettype wire

// ===== rtl/bfa_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_back
// Association engine: scans the previous frame's blobs through a distance
// pipeline, picks the earliest match or a fresh ID, stores the keypoint if
// the table has room and holds the result in an output register.
// ----------------------------------------------------------------------------
module bfa_back #(
  parameter int MAX_BLOBS  = bfa_pkg::MAX_BLOBS_DEF,
  parameter int COORD_BITS = bfa_pkg::COORD_BITS_DEF,
  parameter int ID_BITS    = bfa_pkg::ID_BITS_DEF,
  parameter int Q_W        = bfa_pkg::CMD_W + 2 * COORD_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [bfa_pkg::RADIUS_W-1:0]  radius_i,
  input  wire logic                          q_valid_i,
  input  wire logic [Q_W-1:0]                q_data_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [bfa_pkg::OUT_ID_W-1:0]       blob_id_o,
  output logic                               matched_o,
  output logic                               dropped_o,
  output logic                               frame_done_o
);
  import bfa_pkg::*;

  localparam int IDX_W = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOBS + 1);
  localparam int ENT_W = ID_BITS + 2 * COORD_BITS;
  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int SUM_W = SQ_W + 1;
  localparam int CMP_W = (SUM_W > RADIUS_W) ? SUM_W : RADIUS_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOBS);

  bfa_state_e state_q, state_d;

  logic [ENT_W-1:0] mem [2][MAX_BLOBS];

  cmd_e                  q_kind;
  logic [COORD_BITS-1:0] q_x, q_y;

  logic [COORD_BITS-1:0] item_x_q, item_y_q;
  logic                  item_end_q;

  logic                  bank_q;
  logic [CNT_W-1:0]      prev_cnt_q, cur_cnt_q, issue_idx_q;
  logic [ID_BITS-1:0]    next_id_q, next_id_inc, id_sel;
  logic                  match_q;
  logic [ID_BITS-1:0]    match_id_q;

  logic                  rd_vld_q;
  logic [ENT_W-1:0]      rd_data_q;
  logic                  sq_vld_q;
  logic [SQ_W-1:0]       sqx_q, sqy_q;
  logic [ID_BITS-1:0]    sq_id_q;

  logic [COORD_BITS-1:0] ent_x, ent_y, dx, dy;
  logic [CMP_W-1:0]      dist_sum;
  logic                  hit;

  logic pop, issue, fin, close_now, store;

  logic                  out_vld_q;
  logic [OUT_ID_W-1:0]   out_id_q;
  logic                  out_match_q, out_drop_q, out_end_q;

  assign q_kind = cmd_e'(q_data_i[Q_W-1 -: CMD_W]);
  assign q_y    = q_data_i[2*COORD_BITS-1 -: COORD_BITS];
  assign q_x    = q_data_i[COORD_BITS-1:0];

  // distance pipeline: registered read, squares, then sum and compare
  assign ent_x = rd_data_q[COORD_BITS-1:0];
  assign ent_y = rd_data_q[2*COORD_BITS-1 -: COORD_BITS];
  assign dx    = (ent_x >= item_x_q) ? ent_x - item_x_q : item_x_q - ent_x;
  assign dy    = (ent_y >= item_y_q) ? ent_y - item_y_q : item_y_q - ent_y;

  assign dist_sum = CMP_W'(sqx_q) + CMP_W'(sqy_q);
  assign hit      = sq_vld_q && (dist_sum < CMP_W'(radius_i));

  always_comb begin
    state_d   = state_q;
    pop       = 1'b0;
    issue     = 1'b0;
    fin       = 1'b0;
    close_now = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          pop = 1'b1;
          if (q_kind == CMD_CLOSE) begin
            close_now = 1'b1;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_d = ST_FINISH;
        end else if (issue_idx_q < prev_cnt_q) begin
          issue = 1'b1;
        end else if (!rd_vld_q && !sq_vld_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_vld_q || !out_stall_i) begin
          fin     = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign q_pop_o = pop;

  assign next_id_inc = next_id_q + ID_BITS'(1);
  assign id_sel      = match_q ? match_id_q : next_id_q;
  assign store       = (cur_cnt_q < CNT_MAX);

  always_ff @(posedge clk_i) begin
    if (fin && store) begin
      mem[bank_q][cur_cnt_q[IDX_W-1:0]] <= {id_sel, item_y_q, item_x_q};
    end
    if (issue) begin
      rd_data_q <= mem[~bank_q][issue_idx_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      item_x_q   <= q_x;
      item_y_q   <= q_y;
      item_end_q <= (q_kind == CMD_POINT_END);
    end
    sqx_q   <= SQ_W'(dx) * SQ_W'(dx);
    sqy_q   <= SQ_W'(dy) * SQ_W'(dy);
    sq_id_q <= rd_data_q[ENT_W-1 -: ID_BITS];
    if (hit) begin
      match_id_q <= sq_id_q;
    end
    if (fin) begin
      out_id_q    <= OUT_ID_W'(id_sel);
      out_match_q <= match_q;
      out_drop_q  <= !store;
      out_end_q   <= item_end_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bank_q      <= 1'b0;
      prev_cnt_q  <= '0;
      cur_cnt_q   <= '0;
      issue_idx_q <= '0;
      next_id_q   <= ID_BITS'(1);
      match_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      sq_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      // stages flush once a hit is found or the scan ends
      rd_vld_q <= issue;
      sq_vld_q <= rd_vld_q && !hit && (state_q == ST_SCAN);

      if (pop) begin
        issue_idx_q <= '0;
        match_q     <= 1'b0;
      end else if (issue) begin
        issue_idx_q <= issue_idx_q + CNT_W'(1);
      end
      if (hit) begin
        match_q <= 1'b1;
      end

      if (close_now) begin
        prev_cnt_q <= cur_cnt_q;
        cur_cnt_q  <= '0;
        bank_q     <= ~bank_q;
      end else if (fin) begin
        if (item_end_q) begin
          prev_cnt_q <= cur_cnt_q + CNT_W'(store);
          cur_cnt_q  <= '0;
          bank_q     <= ~bank_q;
        end else begin
          cur_cnt_q  <= cur_cnt_q + CNT_W'(store);
        end
      end

      if (fin && !match_q) begin
        next_id_q <= (next_id_inc == '0) ? ID_BITS'(1) : next_id_inc;
      end

      if (fin) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign blob_id_o    = out_id_q;
  assign matched_o    = out_match_q;
  assign dropped_o    = out_drop_q;
  assign frame_done_o = out_end_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_cnt_q <= CNT_MAX && prev_cnt_q <= CNT_MAX)
    else $error("blob count beyond table depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_id_q != '0)
    else $error("fresh ID counter reached zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> state_q == ST_SCAN)
    else $error("distance hit outside a scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> issue_idx_q < prev_cnt_q)
    else $error("read beyond the previous frame's entries");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_FINISH))
    else $error("result shown without a finished item");

endmodule
`default_nettype wire
